### hdl/gsqr_pkg.sv
`default_nettype none

package gsqr_pkg;

    localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] NEG_MIN = 48'sh8000_0000_0000;
    localparam logic [51:0] MAG_POS_LIMIT = 52'h0_7FFF_FFFF_FFFF;
    localparam logic [51:0] MAG_NEG_LIMIT = 52'h0_8000_0000_0000;

    typedef enum logic [4:0] {
        S_LOAD,
        S_NORM_RD,
        S_NORM_MUL,
        S_NORM_WAIT,
        S_ROOT,
        S_ROOT_WAIT,
        S_QDIV_RD,
        S_QDIV_START,
        S_QDIV_WAIT,
        S_QZERO,
        S_J_CHECK,
        S_DOT_RD,
        S_DOT_MUL,
        S_DOT_WAIT,
        S_RWRITE,
        S_SUB_RD,
        S_SUB_MUL,
        S_SUB_WAIT,
        S_NEXT_COL,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    // sign a magnitude and saturate to 48 bits
    function automatic logic signed [47:0] sat_mag(
        input logic [51:0] mag,
        input logic        neg,
        input logic        over
    );
        logic signed [47:0] res;
        if (neg)
        begin
            if (over || mag >= MAG_NEG_LIMIT)
                res = NEG_MIN;
            else
                res = 48'(52'd0 - mag);
        end
        else
        begin
            if (over || mag > MAG_POS_LIMIT)
                res = POS_MAX;
            else
                res = 48'(mag);
        end
        return res;
    endfunction

    // saturate a 49-bit sum to 48 bits
    function automatic logic signed [47:0] sat_sum(input logic [48:0] v);
        logic signed [47:0] res;
        if (!v[48] && v[47])
            res = POS_MAX;
        else if (v[48] && !v[47])
            res = NEG_MIN;
        else
            res = v[47:0];
        return res;
    endfunction

endpackage

`default_nettype wire

### hdl/gsqr_ram.sv
`default_nettype none

module gsqr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/gsqr_mul.sv
`default_nettype none

module gsqr_mul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [47:0] a,
    input  wire logic signed [47:0] b,
    output logic                    done,
    output logic signed [47:0]      result
);

    import gsqr_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [2:0]  step_reg, step_next;
    logic [47:0] ua_reg, ub_reg;
    logic        neg_reg;
    logic [50:0] acc_reg, acc_next;
    logic        over_reg, over_next;
    logic signed [47:0] result_reg, result_next;
    logic [23:0] ma, mb;
    logic [47:0] prod;
    logic [47:0] ua_c, ub_c;

    assign ua_c = a[47] ? (~a + 48'd1) : a;
    assign ub_c = b[47] ? (~b + 48'd1) : b;

    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                ma = ua_reg[23:0];
                mb = ub_reg[23:0];
            end
            3'd1:
            begin
                ma = ua_reg[47:24];
                mb = ub_reg[23:0];
            end
            3'd2:
            begin
                ma = ua_reg[23:0];
                mb = ub_reg[47:24];
            end
            default:
            begin
                ma = ua_reg[47:24];
                mb = ub_reg[47:24];
            end
        endcase
    end

    assign prod = ma * mb;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        acc_next    = acc_reg;
        over_next   = over_reg;
        result_next = result_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 3'd0;
            acc_next  = '0;
            over_next = 1'b0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 3'd1;
            case (step_reg)
                3'd0:
                    acc_next = 51'(prod[47:24]);
                3'd1, 3'd2:
                    acc_next = acc_reg + 51'(prod);
                3'd3:
                begin
                    if (prod[47:24] != 24'd0)
                        over_next = 1'b1;
                    else
                        acc_next = acc_reg + 51'({prod[23:0], 24'd0});
                end
                default:
                begin
                    result_next = sat_mag(52'(acc_reg), neg_reg, over_reg);
                    done_next   = 1'b1;
                    busy_next   = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= ua_c;
            ub_reg  <= ub_c;
            neg_reg <= a[47] ^ b[47];
        end
        acc_reg    <= acc_next;
        over_reg   <= over_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### hdl/gsqr_root.sv
`default_nettype none

module gsqr_root (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [47:0] s,
    output logic                    done,
    output logic signed [47:0]      result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [71:0] x_reg, x_next;
    logic [39:0] rem_reg, rem_next;
    logic [35:0] root_reg, root_next;
    logic signed [47:0] result_reg, result_next;
    logic [39:0] rem_sh, trial;
    logic        ge;

    // two radicand bits per step
    assign rem_sh = {rem_reg[37:0], x_reg[71:70]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        result_next = result_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            x_next    = s[47] ? 72'd0 : {s, 24'd0};
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[34:0], ge};
            x_next    = {x_reg[69:0], 2'b00};
            cnt_next  = cnt_reg + 6'd1;
            if (cnt_reg == 6'd35)
            begin
                busy_next   = 1'b0;
                done_next   = 1'b1;
                result_next = 48'({root_reg[34:0], ge});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### hdl/gsqr_div.sv
`default_nettype none

module gsqr_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [47:0] x,
    input  wire logic signed [47:0] d,
    output logic                    done,
    output logic signed [47:0]      result
);

    import gsqr_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [71:0] x_reg, x_next;
    logic [47:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [47:0] d_reg;
    logic        neg_reg;
    logic        over_reg, over_next;
    logic signed [47:0] result_reg, result_next;
    logic [48:0] rem_sh;
    logic        ge;
    logic [47:0] ux_c;

    assign ux_c   = x[47] ? (~x + 48'd1) : x;
    assign rem_sh = {rem_reg, x_reg[71]};
    assign ge     = rem_sh >= {1'b0, d_reg};

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        over_next   = over_reg;
        result_next = result_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            x_next    = {ux_c, 24'd0};
            rem_next  = '0;
            quo_next  = '0;
            over_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 48'(rem_sh - {1'b0, d_reg}) : rem_sh[47:0];
            x_next   = {x_reg[70:0], 1'b0};
            cnt_next = cnt_reg + 7'd1;
            if (!over_reg)
            begin
                if (quo_reg[47])
                    over_next = 1'b1;
                else
                    quo_next = {quo_reg[46:0], ge};
            end
            if (cnt_reg == 7'd71)
            begin
                busy_next   = 1'b0;
                done_next   = 1'b1;
                result_next = sat_mag(52'(quo_next), neg_reg, over_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg   <= d;
            neg_reg <= x[47];
        end
        x_reg      <= x_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        over_reg   <= over_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### hdl/gram_schmidt_qr_factor.sv
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_ready  | row_index, col_index, elem_value, load_done
// output  | out       | out_valid / out_ready| out_row, out_col, q_value, r_value,
//         |           |                      | zero_norm, last_out
// config  | in        | cfg_valid / cfg_ready| cfg_data (dim_in_use)
//
// a beat with load_done ends loading and starts a run for dimension n (shorter when a
// column norm is zero), paced by the shared 24x24 multiplier (each product with its
// memory read) and the divider (one quotient bit per cycle); then n*n result beats,
// each read from its memories before it is offered on the output channel
// reset clears control state and sets dim_in_use to 8; the memories are not cleared
// out_ready low holds the current result beat; input is taken only between runs
`default_nettype none

module gram_schmidt_qr_factor #(
    parameter int MAX_DIM = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         row_index,
    input  wire logic [2:0]         col_index,
    input  wire logic signed [31:0] elem_value,
    input  wire logic               load_done,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              out_row,
    output logic [2:0]              out_col,
    output logic signed [47:0]      q_value,
    output logic signed [47:0]      r_value,
    output logic                    zero_norm,
    output logic                    last_out,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_data
);

    import gsqr_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = $clog2(MAX_DIM + 1);
    localparam int XW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(32'(r) * MAX_DIM + 32'(c));
    endfunction

    state_t state_reg, state_next;
    logic [3:0]    dim_reg;
    logic [IW-1:0] n_reg, n_next, n_act, n_m1;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic signed [47:0] acc_reg, acc_next;
    logic signed [47:0] rii_reg, rii_next;
    logic [MAX_DIM-1:0] zf_reg, zf_next;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_row_reg, out_col_reg;
    logic signed [47:0] q_value_reg, r_value_reg;
    logic               zero_norm_reg, last_out_reg;
    logic               out_load;

    logic          w_we, q_we, r_we;
    logic [AW-1:0] w_waddr, w_raddr, q_waddr, q_raddr, r_waddr, r_raddr;
    logic [47:0]   w_wdata, q_wdata, r_wdata, w_rdata, q_rdata, r_rdata;
    logic [AW-1:0] load_addr;
    logic          load_in_range;
    logic          in_beat;

    logic               mul_start, mul_done;
    logic signed [47:0] mul_a, mul_b, mul_res;
    logic               root_start, root_done;
    logic signed [47:0] root_res;
    logic               div_start, div_done;
    logic signed [47:0] div_res;
    logic               use_j, emit_phase;

    gsqr_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_work_ram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    gsqr_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_q_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    gsqr_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_r_ram (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    gsqr_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .result(mul_res)
    );

    gsqr_root u_root (
        .clk(clk), .rst_n(rst_n), .start(root_start),
        .s(acc_reg), .done(root_done), .result(root_res)
    );

    gsqr_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .x(w_rdata), .d(rii_reg), .done(div_done), .result(div_res)
    );

    assign in_ready  = (state_reg == S_LOAD);
    assign cfg_ready = 1'b1;
    assign in_beat   = in_valid && in_ready;

    assign load_in_range = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
    assign load_addr     = AW'(32'(row_index) * MAX_DIM + 32'(col_index));

    always_comb
    begin
        if (dim_reg == 4'd0)
            n_act = IW'(1);
        else if (32'(dim_reg) > MAX_DIM)
            n_act = IW'(MAX_DIM);
        else
            n_act = IW'(dim_reg);
    end

    assign n_m1 = IW'(n_reg - IW'(1));

    assign use_j      = state_reg inside {S_DOT_RD, S_DOT_MUL, S_DOT_WAIT,
                                          S_SUB_RD, S_SUB_MUL, S_SUB_WAIT};
    assign emit_phase = state_reg inside {S_EMIT_RD, S_EMIT_OUT};

    assign w_raddr = addr_of(k_reg, use_j ? j_reg : i_reg);
    assign w_waddr = (state_reg == S_LOAD) ? load_addr : addr_of(k_reg, j_reg);
    assign w_wdata = (state_reg == S_LOAD)
                   ? {{8{elem_value[31]}}, elem_value, 8'd0}
                   : sat_sum({w_rdata[47], w_rdata} - {mul_res[47], mul_res});

    assign q_raddr = emit_phase ? addr_of(i_reg, j_reg) : addr_of(k_reg, i_reg);
    assign q_waddr = addr_of(k_reg, i_reg);
    assign q_wdata = (state_reg == S_QZERO) ? 48'd0 : div_res;

    assign r_raddr = addr_of(i_reg, j_reg);
    assign r_waddr = (state_reg == S_ROOT_WAIT) ? addr_of(i_reg, i_reg) : addr_of(i_reg, j_reg);
    assign r_wdata = (state_reg == S_ROOT_WAIT) ? root_res : acc_reg;

    assign mul_a = (state_reg == S_SUB_MUL) ? acc_reg : w_rdata;
    assign mul_b = (state_reg == S_NORM_MUL) ? w_rdata : q_rdata;

    assign out_load = (state_reg == S_EMIT_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        rii_next   = rii_reg;
        zf_next    = zf_reg;
        w_we       = 1'b0;
        q_we       = 1'b0;
        r_we       = 1'b0;
        mul_start  = 1'b0;
        root_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                if (in_beat)
                begin
                    w_we = load_in_range;
                    if (load_done)
                    begin
                        n_next     = n_act;
                        i_next     = '0;
                        k_next     = '0;
                        acc_next   = '0;
                        state_next = S_NORM_RD;
                    end
                end
            end
            S_NORM_RD:
                state_next = S_NORM_MUL;
            S_NORM_MUL:
            begin
                mul_start  = 1'b1;
                state_next = S_NORM_WAIT;
            end
            S_NORM_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next = sat_sum({acc_reg[47], acc_reg} + {mul_res[47], mul_res});
                    if (k_reg == n_m1)
                    begin
                        k_next     = '0;
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        k_next     = k_reg + IW'(1);
                        state_next = S_NORM_RD;
                    end
                end
            end
            S_ROOT:
            begin
                root_start = 1'b1;
                state_next = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    r_we     = 1'b1;
                    rii_next = root_res;
                    zf_next[i_reg[XW-1:0]] = (root_res == 48'sd0);
                    k_next   = '0;
                    state_next = (root_res == 48'sd0) ? S_QZERO : S_QDIV_RD;
                end
            end
            S_QDIV_RD:
                state_next = S_QDIV_START;
            S_QDIV_START:
            begin
                div_start  = 1'b1;
                state_next = S_QDIV_WAIT;
            end
            S_QDIV_WAIT:
            begin
                if (div_done)
                begin
                    q_we = 1'b1;
                    if (k_reg == n_m1)
                    begin
                        j_next     = i_reg + IW'(1);
                        state_next = S_J_CHECK;
                    end
                    else
                    begin
                        k_next     = k_reg + IW'(1);
                        state_next = S_QDIV_RD;
                    end
                end
            end
            S_QZERO:
            begin
                q_we = 1'b1;
                if (k_reg == n_m1)
                begin
                    j_next     = i_reg + IW'(1);
                    state_next = S_J_CHECK;
                end
                else
                    k_next = k_reg + IW'(1);
            end
            S_J_CHECK:
            begin
                k_next   = '0;
                acc_next = '0;
                state_next = (j_reg < n_reg) ? S_DOT_RD : S_NEXT_COL;
            end
            S_DOT_RD:
                state_next = S_DOT_MUL;
            S_DOT_MUL:
            begin
                mul_start  = 1'b1;
                state_next = S_DOT_WAIT;
            end
            S_DOT_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next = sat_sum({acc_reg[47], acc_reg} + {mul_res[47], mul_res});
                    if (k_reg == n_m1)
                    begin
                        k_next     = '0;
                        state_next = S_RWRITE;
                    end
                    else
                    begin
                        k_next     = k_reg + IW'(1);
                        state_next = S_DOT_RD;
                    end
                end
            end
            S_RWRITE:
            begin
                r_we       = 1'b1;
                state_next = S_SUB_RD;
            end
            S_SUB_RD:
                state_next = S_SUB_MUL;
            S_SUB_MUL:
            begin
                mul_start  = 1'b1;
                state_next = S_SUB_WAIT;
            end
            S_SUB_WAIT:
            begin
                if (mul_done)
                begin
                    w_we = 1'b1;
                    if (k_reg == n_m1)
                    begin
                        j_next     = j_reg + IW'(1);
                        state_next = S_J_CHECK;
                    end
                    else
                    begin
                        k_next     = k_reg + IW'(1);
                        state_next = S_SUB_RD;
                    end
                end
            end
            S_NEXT_COL:
            begin
                k_next   = '0;
                acc_next = '0;
                if (i_reg == n_m1)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_NORM_RD;
                end
            end
            S_EMIT_RD:
                state_next = S_EMIT_OUT;
            S_EMIT_OUT:
            begin
                if (out_load)
                begin
                    if (i_reg == n_m1 && j_reg == n_m1)
                        state_next = S_LOAD;
                    else
                    begin
                        if (j_reg == n_m1)
                        begin
                            j_next = '0;
                            i_next = i_reg + IW'(1);
                        end
                        else
                            j_next = j_reg + IW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            dim_reg       <= 4'd8;
            n_reg         <= IW'(1);
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            zf_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            zf_reg        <= zf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                dim_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rii_reg <= rii_next;
        if (out_load)
        begin
            out_row_reg   <= 3'(i_reg);
            out_col_reg   <= 3'(j_reg);
            q_value_reg   <= q_rdata;
            r_value_reg   <= (i_reg > j_reg) ? 48'sd0 : r_rdata;
            zero_norm_reg <= zf_reg[j_reg[XW-1:0]];
            last_out_reg  <= (i_reg == n_m1) && (j_reg == n_m1);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign q_value   = q_value_reg;
    assign r_value   = r_value_reg;
    assign zero_norm = zero_norm_reg;
    assign last_out  = last_out_reg;

    // final beat sits on the diagonal
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_out |-> out_row == out_col)
        else $error("last beat off the diagonal");

    // a zero-norm column has an all-zero Q column
    a_zero_q: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> q_value == 48'sd0)
        else $error("nonzero Q entry in zero-norm column");

    // run dimension stays within the built size
    a_dim_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_LOAD |-> n_reg != '0 && 32'(n_reg) <= MAX_DIM)
        else $error("run dimension out of range");

    // sum of squares never goes negative
    a_norm_sign: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROOT |-> !acc_reg[47])
        else $error("negative sum of squares");

endmodule

`default_nettype wire
